[sv/glob_wildcard_matcher_defines.svh]
// Assertion macros for the checker file of the glob matcher.
`ifndef GLOB_WILDCARD_MATCHER_DEFINES_SVH
`define GLOB_WILDCARD_MATCHER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define GWM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define GWM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[sv/gwm_pkg.sv]
package gwm_pkg;

    localparam logic [7:0] CH_ANY  = 8'h3F;
    localparam logic [7:0] CH_STAR = 8'h2A;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int LEN_FIELD_W   = 6;
    localparam int BYTES_PER_REG = 8;

    localparam logic [CFG_IDX_W-1:0] REG_PAT0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FOLD = 3'd5;

    localparam logic [7:0] UPPER_A  = 8'h41;
    localparam logic [7:0] UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && c >= UPPER_A && c <= UPPER_Z) begin
            r = c | CASE_BIT;
        end
        return r;
    endfunction

endpackage

[sv/gwm_step.sv]
module gwm_step
    import gwm_pkg::*;
#(
    parameter int N = 32,
    localparam int LEN_W = $clog2(N + 1)
) (
    input  logic [N-1:0][7:0] pat,
    input  logic [LEN_W-1:0]  len,
    input  logic              fold_en,
    input  logic [N:0]        base_set,
    input  logic [7:0]        data_byte,
    input  logic              empty,
    output logic [N:0]        adv_set,
    output logic              matched
);

    localparam int LV = $clog2(N + 1);

    logic [N-1:0] star;
    logic [N-1:0] hit;
    logic [N:0]   len_mask;
    logic [N:0]   c1;
    logic [N:0]   c2;

    // Star closure as a parallel prefix: a live position spreads across a run of stars.
    function automatic logic [N:0] closure(input logic [N:0] s, input logic [N:0] m,
                                           input logic [N-1:0] st);
        logic [N:0] g;
        logic [N:0] p;
        logic [N:0] gn;
        logic [N:0] pn;
        int sh;
        g = s & m;
        p = '0;
        for (int i = 1; i <= N; i++) begin
            p[i] = st[i-1];
        end
        for (int k = 0; k < LV; k++) begin
            sh = 1 << k;
            gn = g;
            pn = '0;
            for (int i = sh; i <= N; i++) begin
                gn[i] = g[i] | (p[i] & g[i-sh]);
                pn[i] = p[i] & p[i-sh];
            end
            g = gn;
            p = pn;
        end
        return g;
    endfunction

    always_comb begin
        for (int i = 0; i < N; i++) begin
            star[i] = (LEN_W'(i) < len) && (pat[i] == CH_STAR);
            hit[i]  = (LEN_W'(i) < len) && (pat[i] != CH_STAR)
                      && ((pat[i] == CH_ANY)
                          || (fold_byte(pat[i], fold_en) == fold_byte(data_byte, fold_en)));
        end
        for (int i = 0; i <= N; i++) begin
            len_mask[i] = ((LEN_W + 1)'(i) <= {1'b0, len});
        end
    end

    assign c1 = closure(base_set, len_mask, star);

    always_comb begin
        adv_set = '0;
        for (int i = 0; i < N; i++) begin
            if (c1[i] && star[i]) begin
                adv_set[i] = 1'b1;
            end
            if (c1[i] && hit[i]) begin
                adv_set[i+1] = 1'b1;
            end
        end
    end

    assign c2 = closure(adv_set, len_mask, star);

    assign matched = empty ? c1[len] : c2[len];

endmodule

[sv/glob_wildcard_matcher.sv]
// Glob pattern matcher for streamed byte strings.
// Configuration: write the pattern bytes (eight per register), the pattern length and
// the case-folding flag over the cfg channel while no value is in flight. '?' matches
// one byte, '*' any run of bytes, everything else matches literally.
// Input: one word per value byte on s_; s_tlast marks the final byte of a value and
// s_tuser marks an empty value that carries no byte and ends on that word.
// Output: one word on m_ per finished value, with the match flag in m_tdata bit 0.
// A result is registered once its ending word has left the input register.
// Throughput: one word per cycle while results are taken; the live set is updated by
// one register stage of prefix logic, so consecutive words never wait on each other.
// A stalled receiver holds the result register; bytes that do not end a value keep
// flowing, and an ending word waits in the input register until the result is taken.
// Reset clears both valid flags, the configuration and leaves only the start position
// live. cfg_ready is always high.
module glob_wildcard_matcher
    import gwm_pkg::*;
#(
    parameter int PATTERN_MAX = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // value_byte
    input  logic                  s_tlast,   // end_of_value
    input  logic                  s_tuser,   // empty_value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // matched, then zero padding
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int N     = PATTERN_MAX;
    localparam int LEN_W = $clog2(N + 1);

    logic [N-1:0][7:0]      pat_reg;
    logic [LEN_FIELD_W-1:0] len_raw_reg;
    logic                   fold_reg;
    logic [LEN_W-1:0]       len;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       in_empty_reg;

    logic [N:0] live_reg;
    logic [N:0] live_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_matched_reg;
    logic       out_matched_next;

    logic       ends;
    logic       fire;
    logic       in_take;
    logic [N:0] base_set;
    logic [N:0] adv_set;
    logic       matched;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg     <= '0;
            len_raw_reg <= '0;
            fold_reg    <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            for (int j = 0; j < N; j++) begin
                if (cfg_index <= REG_PAT3 && cfg_index == REG_PAT0 + CFG_IDX_W'(j >> 3)) begin
                    pat_reg[j] <= cfg_data[(j & (BYTES_PER_REG - 1)) * 8 +: 8];
                end
            end
            if (cfg_index == REG_LEN) begin
                len_raw_reg <= cfg_data[LEN_FIELD_W-1:0];
            end
            if (cfg_index == REG_FOLD) begin
                fold_reg <= cfg_data[0];
            end
        end
    end

    assign len = (len_raw_reg > LEN_FIELD_W'(N)) ? LEN_W'(N) : LEN_W'(len_raw_reg);

    assign ends     = in_last_reg | in_empty_reg;
    assign fire     = in_valid_reg && (!ends || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign in_take  = s_tvalid && s_tready;
    assign base_set = in_empty_reg ? (N + 1)'(1) : live_reg;

    gwm_step #(
        .N (N)
    ) u_step (
        .pat       (pat_reg),
        .len       (len),
        .fold_en   (fold_reg),
        .base_set  (base_set),
        .data_byte (in_byte_reg),
        .empty     (in_empty_reg),
        .adv_set   (adv_set),
        .matched   (matched)
    );

    always_comb begin
        in_valid_next    = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        live_next        = live_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_matched_next = out_matched_reg;
        if (fire) begin
            live_next = ends ? (N + 1)'(1) : adv_set;
            if (ends) begin
                out_valid_next   = 1'b1;
                out_matched_next = matched;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            live_reg      <= (N + 1)'(1);
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            live_reg      <= live_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_byte_reg  <= s_tdata;
            in_last_reg  <= s_tlast;
            in_empty_reg <= s_tuser;
        end
        out_matched_reg <= out_matched_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_matched_reg};

endmodule

[sv/gwm_checker.sv]
`include "glob_wildcard_matcher_defines.svh"

module gwm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       end_in;
    logic       res_out;

    assign end_in  = s_tvalid && s_tready && (s_tlast || s_tuser);
    assign res_out = m_tvalid && m_tready;

    always_comb begin
        pend_next = pend_reg;
        if (end_in && !res_out) begin
            pend_next = pend_reg + 2'd1;
        end else if (!end_in && res_out) begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    `GWM_ASSERT(result_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "Stalled result changed")
    `GWM_ASSERT_ALWAYS(reset_clears, !aresetn |=> !m_tvalid, "Result valid after reset")
    `GWM_ASSERT(result_has_cause, res_out |-> pend_reg != 2'd0, "Result without an ending word")
    `GWM_ASSERT(pending_bounded, pend_reg != 2'd3, "More than two values in flight")

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (.*);

[tb/sv/glob_wildcard_matcher_tb.sv]
`timescale 1ns / 1ps

module glob_wildcard_matcher_tb;
    import gwm_pkg::*;

    localparam int PATTERN_MAX = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 80;
    localparam int RANDOM_PHASES = 11;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // value_byte
    logic                  s_tlast;   // end_of_value
    logic                  s_tuser;   // empty_value
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;   // matched, then zero padding
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [63:0] pat_reg [4];
    logic [5:0]  pat_len_reg;
    logic        fold_reg;
    logic [32:0] live_set;

    bit          expected_match_q[$];
    logic [7:0]  value_q[$];
    int          err_count = 0;
    int          words_sent = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          no_idle = 1'b0;

    glob_wildcard_matcher #(
        .PATTERN_MAX(PATTERN_MAX)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("glob_wildcard_matcher_tb: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 11);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Outputs and our inputs are stable at the falling edge, so what is seen here is
    // exactly what the next rising edge transfers.
    always @(negedge aclk) begin
        bit want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_match_q.size() == 0) begin
                report_mismatch("result word with no value pending", m_tdata, 8'h00);
            end else begin
                want = expected_match_q.pop_front();
                if (m_tdata !== {7'd0, want}) begin
                    report_mismatch("match flag", m_tdata, {7'd0, want});
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("[%0t] mismatch on %s: got %02h, expected %02h", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic logic [7:0] pattern_at(input int i);
        return pat_reg[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function automatic int active_len();
        return (pat_len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len_reg);
    endfunction

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        if (fold_reg && c >= UPPER_A && c <= UPPER_Z) begin
            return c + CASE_BIT;
        end
        return c;
    endfunction

    function automatic logic [32:0] star_closure(input logic [32:0] set, input int len);
        int i;
        for (i = 0; i <= PATTERN_MAX; i++) begin
            if (i > len) begin
                set[i] = 1'b0;
            end
        end
        for (i = 0; i < len; i++) begin
            if (set[i] && pattern_at(i) == CH_STAR) begin
                set[i + 1] = 1'b1;
            end
        end
        return set;
    endfunction

    function automatic logic [32:0] step_positions(input logic [32:0] set, input int len,
                                                   input logic [7:0] c);
        logic [32:0] next;
        logic [7:0]  p;
        int          i;
        next = '0;
        for (i = 0; i < len; i++) begin
            if (set[i]) begin
                p = pattern_at(i);
                if (p == CH_STAR) begin
                    next[i] = 1'b1;
                end else if (p == CH_ANY || fold_char(p) == fold_char(c)) begin
                    next[i + 1] = 1'b1;
                end
            end
        end
        return next;
    endfunction

    function automatic logic [7:0] random_text_byte();
        logic [7:0] letters [4];
        letters = '{8'h61, 8'h41, 8'h62, 8'h42};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return letters[$urandom_range(0, 3)];
            4: return CH_STAR;
            5: return CH_ANY;
            6: return 8'h00;
            7: return $urandom_range(0, 1) ? UPPER_A - 8'd1 : UPPER_Z + 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [255:0] text_pattern(input string s);
        logic [255:0] bits;
        int           i;
        for (i = 0; i < 32; i++) begin
            bits[i * 8 +: 8] = (i < s.len()) ? s[i] : 8'($urandom);
        end
        return bits;
    endfunction

    task automatic load_pattern(input logic [255:0] bytes, input logic [5:0] len,
                                input logic fold);
        logic [63:0] data;
        bit          hs;
        int          k;
        for (k = 0; k < 6; k++) begin
            data = {$urandom, $urandom};
            if (k < 4) begin
                data = bytes[k * 64 +: 64];
                cfg_index <= REG_PAT0 + CFG_IDX_W'(k);
            end else if (k == 4) begin
                data[5:0] = len;
                cfg_index <= REG_LEN;
            end else begin
                data[0] = fold;
                cfg_index <= REG_FOLD;
            end
            cfg_valid <= 1'b1;
            cfg_data <= data;
            do begin
                @(negedge aclk);
                hs = cfg_ready;
                @(posedge aclk);
            end while (!hs);
            if (k < 4) begin
                pat_reg[k] = data;
            end else if (k == 4) begin
                pat_len_reg = data[5:0];
            end else begin
                fold_reg = data[0];
            end
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_word(input logic [7:0] b, input bit last, input bit empty);
        logic [32:0] set;
        bit          hs;
        int          len;
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        s_tuser <= empty;
        do begin
            @(negedge aclk);
            hs = s_tready;
            @(posedge aclk);
        end while (!hs);
        words_sent++;
        len = active_len();
        if (empty) begin
            set = star_closure(33'd1, len);
            expected_match_q.push_back(set[len]);
            live_set = 33'd1;
        end else begin
            live_set = step_positions(star_closure(live_set, len), len, b);
            if (last) begin
                set = star_closure(live_set, len);
                expected_match_q.push_back(set[len]);
                live_set = 33'd1;
            end
        end
    endtask

    task automatic send_value();
        int i;
        if (value_q.size() == 0) begin
            send_word(8'($urandom), 1'($urandom), 1'b1);
        end else begin
            for (i = 0; i < value_q.size(); i++) begin
                send_word(value_q[i], i == value_q.size() - 1, 1'b0);
            end
        end
    endtask

    task automatic send_text(input string s);
        int i;
        value_q.delete();
        for (i = 0; i < s.len(); i++) begin
            value_q.push_back(s[i]);
        end
        send_value();
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_match_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic build_matching_value();
        logic [7:0] p;
        logic [7:0] c;
        int         i;
        value_q.delete();
        for (i = 0; i < active_len(); i++) begin
            p = pattern_at(i);
            if (p == CH_STAR) begin
                repeat ($urandom_range(0, 3)) value_q.push_back(random_text_byte());
            end else if (p == CH_ANY) begin
                value_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                c = p;
                if (fold_reg && fold_char(p) >= 8'h61 && fold_char(p) <= 8'h7A
                    && $urandom_range(0, 1)) begin
                    c = p ^ CASE_BIT;
                end
                value_q.push_back(c);
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_text("");
        send_text("a");
        wait_idle();
    endtask

    task automatic test_directed_patterns();
        logic [255:0] bits;
        int           i;
        load_pattern(text_pattern("a*b?c"), 6'd5, 1'b0);
        send_text("abzc");
        send_text("ab");
        wait_idle();
        load_pattern(text_pattern("***"), 6'd3, 1'b0);
        send_word(8'hFF, 1'b1, 1'b1);
        wait_idle();
        load_pattern(text_pattern("a?"), 6'd2, 1'b1);
        send_text("A*");
        wait_idle();
        bits = text_pattern("");
        bits[7:0] = 8'h00;
        bits[15:8] = CH_ANY;
        load_pattern(bits, 6'd2, 1'b0);
        value_q = '{8'h00, 8'hFF};
        send_value();
        wait_idle();
        load_pattern(text_pattern("@Z["), 6'd3, 1'b1);
        send_text("@z[");
        send_text("`z{");
        wait_idle();
        bits = text_pattern("");
        for (i = 0; i < 31; i++) begin
            bits[i * 8 +: 8] = CH_STAR;
        end
        bits[31 * 8 +: 8] = 8'h71;
        load_pattern(bits, 6'd63, 1'b0);
        send_text("q");
        send_text("");
        wait_idle();
        load_pattern(text_pattern("a"), 6'd1, 1'b0);
        send_text("");
        wait_idle();
        load_pattern(text_pattern("x*"), 6'd2, 1'b0);
        send_text("*");
        wait_idle();
        load_pattern(text_pattern("*"), 6'd1, 1'b1);
        send_text("*");
        wait_idle();
    endtask

    task automatic load_random_pattern();
        logic [255:0] bits;
        logic [5:0]   len;
        int           i;
        case ($urandom_range(0, 15))
            0: len = 6'd0;
            1: len = 6'd32;
            2: len = 6'($urandom_range(33, 63));
            default: len = 6'($urandom_range(1, 10));
        endcase
        for (i = 0; i < 32; i++) begin
            if (i >= len) begin
                bits[i * 8 +: 8] = 8'($urandom);
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: bits[i * 8 +: 8] = CH_STAR;
                    3, 4: bits[i * 8 +: 8] = CH_ANY;
                    default: bits[i * 8 +: 8] = random_text_byte();
                endcase
            end
        end
        load_pattern(bits, len, 1'($urandom));
    endtask

    task automatic run_random_phase();
        int phase_end;
        int n;
        phase_end = words_sent + PHASE_WORDS;
        while (words_sent < phase_end) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    build_matching_value();
                    case ($urandom_range(0, 5))
                        0: if (value_q.size() != 0)
                               value_q[$urandom_range(0, value_q.size() - 1)] =
                                   random_text_byte();
                        1: if (value_q.size() != 0) void'(value_q.pop_back());
                        2: value_q.push_back(random_text_byte());
                        default: ;
                    endcase
                    send_value();
                end
                6: begin
                    value_q.delete();
                    repeat ($urandom_range(1, 6)) value_q.push_back(random_text_byte());
                    send_value();
                end
                7: send_word(8'($urandom), 1'($urandom), 1'b1);
                8: begin
                    n = $urandom_range(1, 3);
                    repeat (n) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
                default: begin
                    value_q.delete();
                    repeat ($urandom_range(1, 5)) value_q.push_back(8'($urandom_range(0, 255)));
                    send_value();
                end
            endcase
        end
        wait_idle();
    endtask

    task automatic test_random_values();
        repeat (RANDOM_PHASES) begin
            load_random_pattern();
            run_random_phase();
        end
    endtask

    task automatic test_full_rate();
        no_idle = 1'b1;
        load_random_pattern();
        run_random_phase();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_PAT0;
        cfg_data = '0;
        pat_reg = '{64'd0, 64'd0, 64'd0, 64'd0};
        pat_len_reg = 6'd0;
        fold_reg = 1'b0;
        live_set = 33'd1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_directed_patterns();
        test_random_values();
        test_full_rate();

        if (err_count == 0) begin
            $display("glob_wildcard_matcher_tb: PASS");
        end else begin
            $display("glob_wildcard_matcher_tb: FAIL");
        end
        $finish;
    end

endmodule
